// File: rtl/afpd_pkg.sv
// package with types and constants of the ask frame packet decoder
`timescale 1ns / 1ps
`default_nettype none

package afpd_pkg;

  // default depth of the message byte store
  localparam int unsigned MaxMsgDef = 32;

  // headers that force a message length of one
  localparam logic [7:0] HdrSig = 8'h01;
  localparam logic [7:0] HdrCe  = 8'h03;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_START_BAD = 3'd1,
    STAT_PARITY_BAD = 3'd2,
    STAT_STOP_BAD  = 3'd3,
    STAT_CHK_BAD   = 3'd4
  } status_e;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  // input beat
  typedef struct packed {
    logic [10:0] frame;
    logic [7:0]  slot;
  } in_beat_t;

  // output beat
  typedef struct packed {
    status_e     status;
    logic [7:0]  payload;
    logic [7:0]  msg_len;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/ask_frame_packet_decoder_top.sv
// ask frame packet decoder: frame checks, header and message store, checksum walk
// frames that need no checksum: the input beat is registered into the working registers
//   in ST_IDLE, then ST_EMIT loads the output register; the checksum frame passes through
//   ST_WALK first, one memory read per byte for n = min(msg_len, MAX_MSG) bytes
// one frame at a time; ST_EMIT waits while the output register is held by out_stall_i,
//   and the next frame is taken once the result is loaded into the output register
// reset clears header, length and control state; the message memory keeps its contents
`timescale 1ns / 1ps
`default_nettype none

module ask_frame_packet_decoder_top #(
  parameter int unsigned MAX_MSG = afpd_pkg::MaxMsgDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire afpd_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output afpd_pkg::out_beat_t      out_data_o
);

  localparam int unsigned AW = (MAX_MSG > 1) ? $clog2(MAX_MSG) : 1;
  localparam int unsigned CW = $clog2(MAX_MSG + 1);

  afpd_pkg::state_e  state_q, state_d;
  afpd_pkg::status_e stat_q;
  afpd_pkg::out_beat_t out_q;

  logic [7:0]    hdr_q;
  logic [7:0]    len_q;
  logic [7:0]    data_q;
  logic [7:0]    sum_q;
  logic          par_bad_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] n_q;
  logic          rd_vld_q;
  logic          out_valid_q;
  logic [7:0]    mem_q [MAX_MSG];
  logic [7:0]    rd_data_q;

  logic          in_fire;
  logic          out_free;
  logic [7:0]    data;
  logic          start_bad;
  logic          stop_bad;
  logic          frame_good;
  logic          par_bad;
  logic          hdr_slot;
  logic          chk_slot;
  logic          msg_slot;
  logic [7:0]    idx;
  logic          mem_we;
  logic          rd_en;
  logic          walk_done;
  logic [CW-1:0] n_d;
  afpd_pkg::status_e acc_stat;

  // frame decode
  assign data       = in_data_i.frame[8:1];
  assign start_bad  = in_data_i.frame[0];
  assign stop_bad   = ~in_data_i.frame[10];
  assign frame_good = ~start_bad & ~stop_bad;
  assign par_bad    = in_data_i.frame[9] != ~(^data);
  assign hdr_slot   = in_data_i.slot == 8'd1;
  assign chk_slot   = {1'b0, in_data_i.slot} == ({1'b0, len_q} + 9'd2);
  assign msg_slot   = (in_data_i.slot >= 8'd2) & ~chk_slot;
  assign idx        = in_data_i.slot - 8'd2;
  assign n_d        = (len_q >= 8'(MAX_MSG)) ? CW'(MAX_MSG) : len_q[CW-1:0];

  // handshake
  assign in_fire   = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign walk_done = (cnt_q == n_q) & ~rd_vld_q;

  // status of a frame that needs no checksum
  always_comb begin
    if (start_bad) begin
      acc_stat = afpd_pkg::STAT_START_BAD;
    end else if (stop_bad) begin
      acc_stat = afpd_pkg::STAT_STOP_BAD;
    end else if (par_bad) begin
      acc_stat = afpd_pkg::STAT_PARITY_BAD;
    end else begin
      acc_stat = afpd_pkg::STAT_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afpd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (frame_good & chk_slot) ? afpd_pkg::ST_WALK : afpd_pkg::ST_EMIT;
        end
      end
      afpd_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = afpd_pkg::ST_EMIT;
        end
      end
      afpd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = afpd_pkg::ST_IDLE;
        end
      end
      default: state_d = afpd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    case (state_q)
      afpd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_we     = in_fire & frame_good & msg_slot & (idx < 8'(MAX_MSG));
      end
      afpd_pkg::ST_WALK: begin
        rd_en = cnt_q != n_q;
      end
      afpd_pkg::ST_EMIT: begin
        in_stall_o = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afpd_pkg::ST_IDLE;
      hdr_q       <= 8'd0;
      len_q       <= 8'd0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      // header and length update
      if (in_fire & frame_good & hdr_slot) begin
        hdr_q <= data;
        if (data == afpd_pkg::HdrSig || data == afpd_pkg::HdrCe) begin
          len_q <= 8'd1;
        end
      end
      // output register valid
      if (state_q == afpd_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers of the current frame
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q    <= data;
      par_bad_q <= par_bad;
      stat_q    <= acc_stat;
      sum_q     <= hdr_q;
      cnt_q     <= '0;
      n_q       <= n_d;
    end
    // checksum walk, one byte per cycle
    if (state_q == afpd_pkg::ST_WALK) begin
      if (rd_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (rd_vld_q) begin
        sum_q <= sum_q + rd_data_q;
      end
      if (walk_done) begin
        if (sum_q != data_q) begin
          stat_q <= afpd_pkg::STAT_CHK_BAD;
        end else if (par_bad_q) begin
          stat_q <= afpd_pkg::STAT_PARITY_BAD;
        end else begin
          stat_q <= afpd_pkg::STAT_OK;
        end
      end
    end
    // load output beat
    if (state_q == afpd_pkg::ST_EMIT && out_free) begin
      out_q.status  <= stat_q;
      out_q.payload <= data_q;
      out_q.msg_len <= len_q;
    end
  end

  // message byte memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx[AW-1:0]] <= data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
